// File: hw/rtl/sccr_pkg.sv
// Shared types and constants for the sector cache tag and replacement block.
package sccr_pkg;

  localparam int ENTRIES      = 64;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int FILE_W       = 16;
  localparam int SECTOR_W     = 22;
  localparam int OFFSET_W     = 31;
  localparam int TAG_W        = 2 + FILE_W + SECTOR_W;

  typedef enum logic [1:0] {
    OP_READ       = 2'd0,
    OP_WRITE      = 2'd1,
    OP_FLUSH_ALL  = 2'd2,
    OP_FLUSH_FILE = 2'd3
  } op_t;

  // One tag RAM word; only meaningful while the entry's valid bit is set.
  typedef struct packed {
    logic                referenced;
    logic                dirty;
    logic [FILE_W-1:0]   file;
    logic [SECTOR_W-1:0] sector;
  } tag_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]    entry_index;
    logic                was_hit;
    logic                fill_needed;
    logic                writeback_needed;
    logic [FILE_W-1:0]   victim_file;
    logic [SECTOR_W-1:0] victim_sector;
    logic                last_result;
  } result_t;

endpackage

// File: hw/rtl/sccr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sccr_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 40
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/sccr_out_reg.sv
// Result output register: holds one item until the consumer takes it.
module sccr_out_reg
  import sccr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t res,
  output logic    can_push,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t data
);

  assign can_push = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= res;
    end
  end

endmodule

// File: hw/rtl/sector_cache_clock_replacement.sv
// Sector cache tag/replacement top level: lookup, clock sweep and flush sequencer.
// Operation: an access scans the tag RAM one entry at a time (one read port, registered
//   data), reading and then evaluating each entry; a hit ends the scan at its entry, a miss
//   scans all ENTRIES and, when it must evict, steps the clock hand (at most ENTRIES+1 steps).
// Flushes scan all entries and can stall on the output; one item is worked on at a time.
// Reset (synchronous, active high) clears all valid bits, the clock hand and the output
//   register; tag RAM contents need no clearing since the valid bits mask stale words.
module sector_cache_clock_replacement
  import sccr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic [FILE_W-1:0]   file_id,
  input  logic [OFFSET_W-1:0] byte_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    entry_index,
  output logic                was_hit,
  output logic                fill_needed,
  output logic                writeback_needed,
  output logic [FILE_W-1:0]   victim_file,
  output logic [SECTOR_W-1:0] victim_sector,
  output logic                last_result
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LK_RD,   // lookup: read tag of idx
    S_LK_EV,   // lookup: compare, track lowest free entry
    S_SW_RD,   // clock sweep: read entry under hand
    S_SW_EV,   // clock sweep: second chance or victim
    S_FILL,    // install new tag, report fill
    S_FL_RD,   // flush: read tag of idx
    S_FL_EV,   // flush: report previous pending, clean this one
    S_FL_END   // flush: last pending item carries last_result
  } state_t;

  state_t              state;
  op_t                 op_q;
  logic [FILE_W-1:0]   fid_q;
  logic [SECTOR_W-1:0] sec_q;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    free_idx;
  logic                have_free;
  logic [IDX_W-1:0]    hand;
  logic [IDX_W-1:0]    slot;
  logic                wb_q;
  logic [FILE_W-1:0]   vf_q;
  logic [SECTOR_W-1:0] vs_q;
  logic                pend_valid;
  result_t             pend;
  logic [ENTRIES-1:0]  valid_bits;

  // RAM port signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  tag_word_t        ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [TAG_W-1:0] ram_rdata;
  tag_word_t        rd;

  // output register signals
  logic    push;
  result_t push_res;
  logic    can_push;
  result_t out_data;

  logic                is_write;
  logic                tag_hit;
  logic                fl_match;
  logic                fl_ok;
  logic                last_idx;
  logic [IDX_W-1:0]    hand_next;
  logic [SECTOR_W-1:0] sec_shift;

  assign rd        = tag_word_t'(ram_rdata);
  assign is_write  = (op_q == OP_WRITE);
  assign tag_hit   = valid_bits[idx] && (rd.file == fid_q) && (rd.sector == sec_q);
  assign fl_match  = valid_bits[idx] && rd.dirty &&
                     ((op_q == OP_FLUSH_ALL) || (rd.file == fid_q));
  // a new match may only replace the pending item once that one has left
  assign fl_ok     = !pend_valid || can_push;
  assign last_idx  = (idx == IDX_W'(ENTRIES - 1));
  assign hand_next = (hand == IDX_W'(ENTRIES - 1)) ? '0 : hand + IDX_W'(1);
  assign sec_shift = SECTOR_W'(byte_offset >> SECTOR_SHIFT);
  assign in_ready  = (state == S_IDLE);

  sccr_ram #(
    .DEPTH(ENTRIES),
    .WIDTH(TAG_W)
  ) u_tag_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sccr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .res      (push_res),
    .can_push (can_push),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .data     (out_data)
  );

  assign entry_index      = out_data.entry_index;
  assign was_hit          = out_data.was_hit;
  assign fill_needed      = out_data.fill_needed;
  assign writeback_needed = out_data.writeback_needed;
  assign victim_file      = out_data.victim_file;
  assign victim_sector    = out_data.victim_sector;
  assign last_result      = out_data.last_result;

  // RAM and output control. Reads happen only in *_RD states and writes only in
  // evaluate/fill states, so a read and a write never meet in one cycle.
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx;
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = rd;
    push      = 1'b0;
    push_res  = '0;
    case (state)
      S_LK_RD, S_FL_RD: begin
        ram_re = 1'b1;
      end
      S_SW_RD: begin
        ram_re    = 1'b1;
        ram_raddr = hand;
      end
      S_LK_EV: begin
        if (tag_hit && can_push) begin
          ram_we               = 1'b1;
          ram_wdata.referenced = 1'b1;
          ram_wdata.dirty      = rd.dirty | is_write;
          push                 = 1'b1;
          push_res.entry_index = idx;
          push_res.was_hit     = 1'b1;
          push_res.last_result = 1'b1;
        end
      end
      S_SW_EV: begin
        ram_waddr            = hand;
        ram_we               = rd.referenced;
        ram_wdata.referenced = 1'b0;
      end
      S_FILL: begin
        ram_waddr                 = slot;
        ram_we                    = can_push;
        ram_wdata.referenced      = 1'b0;
        ram_wdata.dirty           = is_write;
        ram_wdata.file            = fid_q;
        ram_wdata.sector          = sec_q;
        push                      = can_push;
        push_res.entry_index      = slot;
        push_res.fill_needed      = 1'b1;
        push_res.writeback_needed = wb_q;
        push_res.victim_file      = vf_q;
        push_res.victim_sector    = vs_q;
        push_res.last_result      = 1'b1;
      end
      S_FL_EV: begin
        ram_we          = fl_match && fl_ok;
        ram_wdata.dirty = 1'b0;
        push            = fl_match && pend_valid && can_push;
        push_res        = pend;
      end
      S_FL_END: begin
        push                 = pend_valid && can_push;
        push_res             = pend;
        push_res.last_result = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hand       <= '0;
      valid_bits <= '0;
      pend_valid <= 1'b0;
      have_free  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q       <= op_t'(operation);
            fid_q      <= file_id;
            sec_q      <= sec_shift;
            idx        <= '0;
            have_free  <= 1'b0;
            pend_valid <= 1'b0;
            if (operation == OP_READ || operation == OP_WRITE) begin
              state <= S_LK_RD;
            end else begin
              state <= S_FL_RD;
            end
          end
        end
        S_LK_RD: begin
          state <= S_LK_EV;
        end
        S_LK_EV: begin
          if (tag_hit) begin
            if (can_push) begin
              state <= S_IDLE;
            end
          end else begin
            if (!valid_bits[idx] && !have_free) begin
              free_idx  <= idx;
              have_free <= 1'b1;
            end
            if (last_idx) begin
              wb_q <= 1'b0;
              vf_q <= '0;
              vs_q <= '0;
              if (have_free) begin
                slot  <= free_idx;
                state <= S_FILL;
              end else if (!valid_bits[idx]) begin
                slot  <= idx;
                state <= S_FILL;
              end else begin
                state <= S_SW_RD;
              end
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_LK_RD;
            end
          end
        end
        S_SW_RD: begin
          state <= S_SW_EV;
        end
        S_SW_EV: begin
          hand <= hand_next;
          if (rd.referenced) begin
            state <= S_SW_RD;
          end else begin
            slot  <= hand;
            wb_q  <= rd.dirty;
            vf_q  <= rd.dirty ? rd.file : '0;
            vs_q  <= rd.dirty ? rd.sector : '0;
            state <= S_FILL;
          end
        end
        S_FILL: begin
          if (can_push) begin
            valid_bits[slot] <= 1'b1;
            state            <= S_IDLE;
          end
        end
        S_FL_RD: begin
          state <= S_FL_EV;
        end
        S_FL_EV: begin
          if (!fl_match || fl_ok) begin
            if (fl_match) begin
              pend_valid            <= 1'b1;
              pend.entry_index      <= idx;
              pend.was_hit          <= 1'b0;
              pend.fill_needed      <= 1'b0;
              pend.writeback_needed <= 1'b1;
              pend.victim_file      <= rd.file;
              pend.victim_sector    <= rd.sector;
              pend.last_result      <= 1'b0;
            end
            if (last_idx) begin
              state <= S_FL_END;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_FL_RD;
            end
          end
        end
        S_FL_END: begin
          if (!pend_valid || can_push) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the clock sweep only runs when every entry holds a sector
  a_sweep_full: assert property (@(posedge clk) disable iff (rst)
    (state == S_SW_EV) |-> (&valid_bits))
    else $error("clock sweep with a free entry");

  // tag RAM is never read and written at one address in the same cycle
  a_ram_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ram_re && ram_we && (ram_raddr == ram_waddr)))
    else $error("tag RAM read/write overlap");

  // a hit never asks for fill or write-back and always ends its item
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (push && push_res.was_hit) |->
      (!push_res.fill_needed && !push_res.writeback_needed && push_res.last_result))
    else $error("malformed hit result");

  // a flush result always names a write-back
  a_flush_wb: assert property (@(posedge clk) disable iff (rst)
    (push && (state == S_FL_EV || state == S_FL_END)) |-> push_res.writeback_needed)
    else $error("flush result without write-back");

  // reset empties the cache
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (valid_bits == '0) && (hand == '0))
    else $error("cache not empty after reset");

endmodule
